@@ design/bss_pkg.sv @@
`timescale 1ns / 1ps

package bss_pkg;

    // window depth default
    localparam int WINDOW_BYTES_DEF = 16;

    // signature shape
    localparam int PAT_BYTES  = 5;
    localparam int OFS_W      = 4;
    localparam int POS_W      = 32;
    localparam int DISP_BYTES = 4;
    localparam int ADDR_W     = 64;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] REG_MATCH_VALUES  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MATCH_OFFSETS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DECODE_MODE   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REGION_BASE   = 2'd3;

    // decode modes
    localparam logic [1:0] MODE_PLAIN = 2'd0;
    localparam logic [1:0] MODE_CALL  = 2'd1;
    localparam logic [1:0] MODE_MOV   = 2'd2;
    localparam logic [1:0] MODE_LEA   = 2'd3;

    typedef logic [PAT_BYTES-1:0][7:0] pat_bytes_t;

    // candidate result handed from the window to the address pipeline
    typedef struct packed {
        logic                      found;
        logic [POS_W-1:0]          pos;
        logic [1:0]                mode;
        logic [DISP_BYTES*8-1:0]   disp;
    } cand_t;

endpackage

@@ design/bss_in_if.sv @@
`timescale 1ns / 1ps

interface bss_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

@@ design/bss_out_if.sv @@
`timescale 1ns / 1ps

interface bss_out_if;
    logic        valid;
    logic        ready;
    logic        found;
    logic [63:0] result_address;

    modport source (output valid, output found, output result_address, input ready);
    modport sink (input valid, input found, input result_address, output ready);
endinterface

@@ design/bss_cell.sv @@
`timescale 1ns / 1ps

module bss_cell
    import bss_pkg::*;
(
    input  logic                 clk,
    input  logic                 shift,
    input  logic [7:0]           byte_in,
    input  pat_bytes_t           pattern,
    output logic [7:0]           byte_q,
    output logic [PAT_BYTES-1:0] eq
);

    logic [7:0] byte_reg;

    // window byte, moves one place per accepted request
    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            byte_reg <= byte_in;
        end
    end

    assign byte_q = byte_reg;

    // compare incoming byte against every pattern byte
    always_comb
    begin
        for (int k = 0; k < PAT_BYTES; k++)
        begin
            eq[k] = (byte_in == pattern[k]);
        end
    end

endmodule

@@ design/bss_addr.sv @@
`timescale 1ns / 1ps

module bss_addr
    import bss_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cand_valid,
    input  cand_t             cand,
    output logic              cand_ready,
    input  logic [ADDR_W-1:0] region_base,
    bss_out_if.source         result
);

    logic                  s2_valid_reg;
    logic                  s2_found_reg;
    logic [ADDR_W-1:0]     s2_sum_reg;
    logic [POS_W:0]        s2_ofs_reg;
    logic                  out_valid_reg;
    logic                  out_found_reg;
    logic [ADDR_W-1:0]     out_addr_reg;

    logic                  out_free;
    logic [ADDR_W-1:0]     sum_next;
    logic [POS_W:0]        ofs_next;
    logic [ADDR_W-1:0]     addr_next;

    assign out_free   = !out_valid_reg || result.ready;
    assign cand_ready = !s2_valid_reg || out_free;

    // base plus position, and displacement plus instruction length
    always_comb
    begin
        sum_next = region_base + ADDR_W'(cand.pos);
        if (cand.mode == MODE_PLAIN)
        begin
            ofs_next = '0;
        end
        else
        begin
            ofs_next = {cand.disp[POS_W-1], cand.disp}
                     + (POS_W+1)'(cand.mode) + (POS_W+1)'(DISP_BYTES);
        end
    end

    // final add, zero address when nothing matched
    always_comb
    begin
        if (s2_found_reg)
        begin
            addr_next = s2_sum_reg + {{(ADDR_W-POS_W-1){s2_ofs_reg[POS_W]}}, s2_ofs_reg};
        end
        else
        begin
            addr_next = '0;
        end
    end

    // stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cand_ready)
            begin
                s2_valid_reg <= cand_valid;
            end
            if (out_free)
            begin
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (cand_ready && cand_valid)
        begin
            s2_found_reg <= cand.found;
            s2_sum_reg   <= sum_next;
            s2_ofs_reg   <= ofs_next;
        end
        if (out_free && s2_valid_reg)
        begin
            out_found_reg <= s2_found_reg;
            out_addr_reg  <= addr_next;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.found          = out_found_reg;
    assign result.result_address = out_addr_reg;

endmodule

@@ design/byte_signature_scanner.sv @@
`timescale 1ns / 1ps

// byte_signature_scanner
// Searches a byte stream for a five-byte signature at five programmable
// offsets and reports the first hit of each region once.
// Channels: byte_in takes one byte a cycle while ready is high, with a last_byte
// mark on the region's final byte; result gives found and the decoded address,
// or found low and a zero address when the region ended with no hit.
// Configuration is written through cfg_we / cfg_index / cfg_data while the
// block is idle: pattern bytes, offsets, decode mode and region base.
// Throughput: one byte per cycle while byte_in.ready is high, set by the row of
// window cells that all shift and compare in the cycle a byte is taken.
// Pipeline: the compare stage loads on the edge that takes the request, then
// the base add stage, then the displacement add into the output register, where
// result valid rises.
// A stalled result waits in the output register; bytes keep being taken
// until the two stages behind it are also occupied.
// Reset clears the configuration to zero, the fill and position counts and
// the pipeline valid flags; window contents need no reset.
module byte_signature_scanner
    import bss_pkg::*;
#(
    parameter int WINDOW_BYTES = WINDOW_BYTES_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    bss_in_if.sink                byte_in,
    bss_out_if.source             result,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int IDXW = $clog2(WINDOW_BYTES);
    localparam int SUMW = $clog2(WINDOW_BYTES + 16);
    localparam int FW   = $clog2(WINDOW_BYTES + 1);

    localparam logic [SUMW-1:0] TOP_IDX  = SUMW'(WINDOW_BYTES - 1);
    localparam logic [FW-1:0]   FILL_MAX = FW'(WINDOW_BYTES);

    // configuration registers
    logic [PAT_BYTES*8-1:0]     values_reg;
    logic [PAT_BYTES*OFS_W-1:0] offsets_reg;
    logic [1:0]                 mode_reg;
    logic [ADDR_W-1:0]          base_reg;

    // scan state
    logic [FW-1:0]    fill_reg;
    logic [FW-1:0]    fill_next;
    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic             done_reg;
    logic             done_next;

    // candidate stage
    logic  s1_valid_reg;
    cand_t s1_reg;
    cand_t s1_next;
    logic  cand_ready;

    logic       accept;
    logic       hit;
    logic       emit;
    logic [OFS_W-1:0] need;
    pat_bytes_t pattern;

    logic [7:0]           win_q   [WINDOW_BYTES];
    logic [7:0]           win_nxt [WINDOW_BYTES];
    logic [PAT_BYTES-1:0] eq_vec  [WINDOW_BYTES];

    assign byte_in.ready = !s1_valid_reg || cand_ready;
    assign accept        = byte_in.valid && byte_in.ready;
    assign pattern       = values_reg;

    // row of window cells, newest byte enters at the top
    for (genvar j = 0; j < WINDOW_BYTES; j++)
    begin : g_cell
        if (j == WINDOW_BYTES - 1)
        begin : g_head
            assign win_nxt[j] = byte_in.data_byte;
        end
        else
        begin : g_body
            assign win_nxt[j] = win_q[j+1];
        end

        bss_cell u_cell (
            .clk     (clk),
            .shift   (accept),
            .byte_in (win_nxt[j]),
            .pattern (pattern),
            .byte_q  (win_q[j]),
            .eq      (eq_vec[j])
        );
    end

    // lookahead: largest offset, and the displacement end in decode modes
    always_comb
    begin
        logic [OFS_W-1:0] off;
        need = '0;
        for (int k = 0; k < PAT_BYTES; k++)
        begin
            off = offsets_reg[k*OFS_W +: OFS_W];
            if (off > need)
            begin
                need = off;
            end
        end
        if (mode_reg != MODE_PLAIN && (OFS_W'(mode_reg) + OFS_W'(3)) > need)
        begin
            need = OFS_W'(mode_reg) + OFS_W'(3);
        end
    end

    // test the candidate position against the shifted window
    always_comb
    begin
        logic [SUMW-1:0] tmp;
        logic [IDXW-1:0] idx;
        logic            test;

        if (fill_reg == FILL_MAX)
        begin
            fill_next = FILL_MAX;
        end
        else
        begin
            fill_next = fill_reg + FW'(1);
        end

        test = !done_reg && (SUMW'(need) <= TOP_IDX) && (SUMW'(fill_next) > SUMW'(need));

        hit = test;
        for (int k = 0; k < PAT_BYTES; k++)
        begin
            tmp = TOP_IDX - SUMW'(need) + SUMW'(offsets_reg[k*OFS_W +: OFS_W]);
            idx = tmp[IDXW-1:0];
            if (!eq_vec[idx][k])
            begin
                hit = 1'b0;
            end
        end

        s1_next.found = hit;
        s1_next.pos   = pos_reg - POS_W'(need);
        s1_next.mode  = mode_reg;
        for (int i = 0; i < DISP_BYTES; i++)
        begin
            tmp = TOP_IDX - SUMW'(need) + SUMW'(mode_reg) + SUMW'(i);
            idx = tmp[IDXW-1:0];
            s1_next.disp[i*8 +: 8] = win_nxt[idx];
        end

        emit = hit || (byte_in.last_byte && !done_reg);

        if (byte_in.last_byte)
        begin
            done_next = 1'b0;
            pos_next  = '0;
        end
        else
        begin
            done_next = done_reg || hit;
            pos_next  = pos_reg + POS_W'(1);
        end
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            values_reg  <= '0;
            offsets_reg <= '0;
            mode_reg    <= MODE_PLAIN;
            base_reg    <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MATCH_VALUES:  values_reg  <= cfg_data[PAT_BYTES*8-1:0];
                REG_MATCH_OFFSETS: offsets_reg <= cfg_data[PAT_BYTES*OFS_W-1:0];
                REG_DECODE_MODE:   mode_reg    <= cfg_data[1:0];
                REG_REGION_BASE:   base_reg    <= cfg_data[ADDR_W-1:0];
                default:           ;
            endcase
        end
    end

    // region counters and candidate valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg     <= '0;
            pos_reg      <= '0;
            done_reg     <= 1'b0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                fill_reg     <= byte_in.last_byte ? '0 : fill_next;
                pos_reg      <= pos_next;
                done_reg     <= done_next;
                s1_valid_reg <= emit;
            end
            else if (cand_ready)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    // candidate payload
    always_ff @(posedge clk)
    begin
        if (accept && emit)
        begin
            s1_reg <= s1_next;
        end
    end

    bss_addr u_addr (
        .clk         (clk),
        .rst_n       (rst_n),
        .cand_valid  (s1_valid_reg),
        .cand        (s1_reg),
        .cand_ready  (cand_ready),
        .region_base (base_reg),
        .result      (result)
    );

endmodule

@@ test/byte_signature_scanner_tb.sv @@
`timescale 1ns / 1ps

module byte_signature_scanner_tb;
    import bss_pkg::*;

    localparam int ITEM_TARGET = 1850;
    localparam int WIN         = WINDOW_BYTES_DEF;
    localparam int HOLD_CYCLES = 150;
    localparam int SETTLE_CYC  = 8;

    typedef struct packed {
        logic              found;
        logic [ADDR_W-1:0] address;
    } scan_report_t;

    typedef enum int {
        REGION_SIGNATURE,
        REGION_BROKEN,
        REGION_NOISE,
        REGION_TRUNCATED
    } region_shape_t;

    logic clk;
    logic rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    bss_in_if  byte_in_bus ();
    bss_out_if result_bus ();

    byte_signature_scanner uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_in   (byte_in_bus),
        .result    (result_bus),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // predicted configuration, as last programmed
    logic [PAT_BYTES*8-1:0]     sig_values  = '0;
    logic [PAT_BYTES*OFS_W-1:0] sig_offsets = '0;
    logic [1:0]                 sig_mode    = MODE_PLAIN;
    logic [ADDR_W-1:0]          sig_base    = '0;

    // predicted scan state
    logic [7:0]       win [WIN];
    int unsigned      fill_cnt = 0;
    logic [POS_W-1:0] pos_cnt  = '0;
    bit               hit_done = 1'b0;

    scan_report_t pending_reports [$];
    scan_report_t head_report;
    logic [7:0]   region_buf [$];

    int  fail_count   = 0;
    int  items_sent   = 0;
    int  regions_sent = 0;
    int  settings_cnt = 0;
    int  hits_seen    = 0;
    int  misses_seen  = 0;
    bit  quiet        = 1'b0;
    bit  hold_req     = 1'b0;

    // clock
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // overall time limit
    initial
    begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // largest byte distance a candidate position needs under the current setting
    function automatic int lookahead_len();
        int need;
        int k;
        int off;
        need = 0;
        for (k = 0; k < PAT_BYTES; k++)
        begin
            off = int'(sig_offsets[OFS_W*k +: OFS_W]);
            if (off > need)
                need = off;
        end
        if (sig_mode != MODE_PLAIN && int'(sig_mode) + 3 > need)
            need = int'(sig_mode) + 3;
        return need;
    endfunction

    // advance the predicted scan by one accepted byte
    task automatic scan_byte(input logic [7:0] b, input logic last);
        int               need;
        int               k;
        int               off;
        int               d;
        int               base_i;
        bit               hit;
        bit               emitted;
        logic [31:0]      disp;
        logic [ADDR_W-1:0] addr;
        for (k = 0; k < WIN - 1; k++)
            win[k] = win[k+1];
        win[WIN-1] = b;
        if (fill_cnt < WIN)
            fill_cnt++;
        emitted = 1'b0;
        if (!hit_done)
        begin
            need = lookahead_len();
            if (need <= WIN - 1 && fill_cnt >= need + 1)
            begin
                base_i = WIN - 1 - need;
                hit = 1'b1;
                for (k = 0; k < PAT_BYTES; k++)
                begin
                    off = int'(sig_offsets[OFS_W*k +: OFS_W]);
                    if (win[base_i + off] !== sig_values[8*k +: 8])
                        hit = 1'b0;
                end
                if (hit)
                begin
                    addr = sig_base + ADDR_W'(pos_cnt - POS_W'(need));
                    if (sig_mode != MODE_PLAIN)
                    begin
                        d = int'(sig_mode);
                        disp = {win[base_i+d+3], win[base_i+d+2],
                                win[base_i+d+1], win[base_i+d]};
                        addr = addr + ADDR_W'(d) + 64'd4 + {{32{disp[31]}}, disp};
                    end
                    pending_reports.push_back('{found: 1'b1, address: addr});
                    hit_done = 1'b1;
                    emitted = 1'b1;
                end
            end
        end
        if (last)
        begin
            if (!emitted && !hit_done)
                pending_reports.push_back('{found: 1'b0, address: '0});
            fill_cnt = 0;
            pos_cnt  = '0;
            hit_done = 1'b0;
        end
        else
            pos_cnt = pos_cnt + 1'b1;
    endtask

    // input monitor feeds the predictor
    always @(posedge clk)
    begin
        if (rst_n && byte_in_bus.valid && byte_in_bus.ready)
            scan_byte(byte_in_bus.data_byte, byte_in_bus.last_byte);
    end

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && result_bus.valid && result_bus.ready)
        begin
            if (result_bus.found === 1'b1)
                hits_seen++;
            else
                misses_seen++;
            if (pending_reports.size() == 0)
            begin
                $error("unexpected result: found=%0b result_address=%h",
                       result_bus.found, result_bus.result_address);
                fail_count++;
            end
            else
            begin
                head_report = pending_reports.pop_front();
                if (result_bus.found !== head_report.found)
                begin
                    $error("found mismatch: expected %0b actual %0b",
                           head_report.found, result_bus.found);
                    fail_count++;
                end
                if (result_bus.result_address !== head_report.address)
                begin
                    $error("result_address mismatch: expected %h actual %h",
                           head_report.address, result_bus.result_address);
                    fail_count++;
                end
            end
        end
    end

    // receiver: random stall bursts, one long hold-off on request
    initial
    begin : receiver
        int burst;
        result_bus.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                result_bus.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
                result_bus.ready <= 1'b1;
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                burst = $urandom_range(1, 5);
                result_bus.ready <= 1'b0;
                repeat (burst) @(negedge clk);
                result_bus.ready <= 1'b1;
            end
            else
                result_bus.ready <= 1'b1;
        end
    end

    // one byte request, entered and left at a falling edge
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 5);
            byte_in_bus.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        byte_in_bus.valid     <= 1'b1;
        byte_in_bus.data_byte <= b;
        byte_in_bus.last_byte <= last;
        @(posedge clk);
        while (!byte_in_bus.ready)
            @(posedge clk);
        @(negedge clk);
        items_sent++;
    endtask

    task automatic send_region();
        int i;
        for (i = 0; i < region_buf.size(); i++)
            send_byte(region_buf[i], i == region_buf.size() - 1);
        regions_sent++;
    endtask

    // drain everything outstanding, then let the pipeline run empty
    task automatic settle();
        byte_in_bus.valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYC) @(negedge clk);
    endtask

    // write all four registers; unused upper data bits carry junk
    task automatic program_signature(input logic [PAT_BYTES*8-1:0] values,
                                     input logic [PAT_BYTES*OFS_W-1:0] offsets,
                                     input logic [1:0] mode,
                                     input logic [ADDR_W-1:0] base);
        logic [CFG_DATA_W-1:0] words [4];
        logic [CFG_IDX_W-1:0]  ids [4];
        logic [31:0]           junk;
        int                    i;
        junk = $urandom();
        words[0] = {junk[23:0], values};
        words[1] = {junk, junk[11:0], offsets};
        words[2] = {junk, junk[29:0], mode};
        words[3] = base;
        ids[0] = REG_MATCH_VALUES;
        ids[1] = REG_MATCH_OFFSETS;
        ids[2] = REG_DECODE_MODE;
        ids[3] = REG_REGION_BASE;
        for (i = 0; i < 4; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= ids[i];
            cfg_data  <= words[i];
            @(negedge clk);
        end
        cfg_we <= 1'b0;
        @(negedge clk);
        sig_values  = values;
        sig_offsets = offsets;
        sig_mode    = mode;
        sig_base    = base;
        settings_cnt++;
    endtask

    task automatic pick_random_signature();
        logic [63:0]                wide;
        logic [PAT_BYTES*OFS_W-1:0] offsets;
        logic [PAT_BYTES*8-1:0]     values;
        logic [ADDR_W-1:0]          base;
        int                         k;
        int                         r;
        wide = {$urandom(), $urandom()};
        r = $urandom_range(0, 9);
        if (r == 0)
            values = '0;
        else if (r == 1)
            values = '1;
        else
            values = wide[PAT_BYTES*8-1:0];
        // offsets: full range, narrow range, or all at one extreme
        r = $urandom_range(0, 9);
        for (k = 0; k < PAT_BYTES; k++)
        begin
            if (r < 4)
                offsets[OFS_W*k +: OFS_W] = OFS_W'($urandom_range(0, 15));
            else
                offsets[OFS_W*k +: OFS_W] = OFS_W'($urandom_range(0, 5));
        end
        if (r == 8)
            offsets = '0;
        else if (r == 9)
            offsets = '1;
        r = $urandom_range(0, 7);
        if (r == 0)
            base = '0;
        else if (r == 1)
            base = '1;
        else if (r == 2)
            base = ~ADDR_W'($urandom_range(0, 40));
        else
            base = {$urandom(), $urandom()};
        program_signature(values, offsets, 2'($urandom_range(0, 3)), base);
    endtask

    // place the pattern bytes at position p, dropping any past the region end
    task automatic plant_signature(input int p);
        int k;
        int at;
        for (k = 0; k < PAT_BYTES; k++)
        begin
            at = p + int'(sig_offsets[OFS_W*k +: OFS_W]);
            if (at < region_buf.size())
                region_buf[at] = sig_values[8*k +: 8];
        end
    endtask

    task automatic build_region(input region_shape_t shape);
        int need;
        int len;
        int p;
        int k;
        int at;
        need = lookahead_len();
        region_buf.delete();
        if (shape == REGION_TRUNCATED && need == 0)
            shape = REGION_NOISE;
        case (shape)
            REGION_NOISE:     len = $urandom_range(1, 40);
            REGION_TRUNCATED: len = $urandom_range(need + 1, need + 12);
            default:          len = need + 1 + $urandom_range(0, 24);
        endcase
        for (k = 0; k < len; k++)
            region_buf.push_back(8'($urandom()));
        case (shape)
            REGION_SIGNATURE:
            begin
                p = $urandom_range(0, len - 1 - need);
                plant_signature(p);
            end
            REGION_BROKEN:
            begin
                p = $urandom_range(0, len - 1 - need);
                plant_signature(p);
                k = $urandom_range(0, PAT_BYTES - 1);
                at = p + int'(sig_offsets[OFS_W*k +: OFS_W]);
                region_buf[at] = region_buf[at] ^ 8'($urandom_range(1, 255));
            end
            REGION_TRUNCATED:
            begin
                // window of the planted copy runs past the last byte
                p = $urandom_range(len - need, len - 1);
                plant_signature(p);
            end
            default:
            begin
            end
        endcase
    endtask

    // reset configuration: zero pattern at offset zero hits on the very first byte
    task automatic test_reset_defaults();
        region_buf = '{8'h00};
        send_region();
        settle();
    endtask

    // all-ones pattern, base at the top so the address wraps; bytes after a hit stay silent
    task automatic test_plain_wrap();
        program_signature(40'hFF_FFFF_FFFF, '0, MODE_PLAIN, '1);
        region_buf = '{8'h00, 8'hFF, 8'h00};
        send_region();
        settle();
    endtask

    // call displacement, negative, hit on the last byte
    task automatic test_call_mode();
        program_signature(40'hE8_E8E8_E8E8, '0, MODE_CALL, 64'h8);
        region_buf = '{8'hE8, 8'hF0, 8'hFF, 8'hFF, 8'hFF};
        send_region();
        settle();
    endtask

    // mov displacement, positive
    task automatic test_mov_mode();
        program_signature(40'h8B_058B_058B, 20'h01010, MODE_MOV, 64'h0000_7FF0_0000_0000);
        region_buf = '{8'h8B, 8'h05, 8'h78, 8'h56, 8'h34, 8'h12};
        send_region();
        settle();
    endtask

    // lea: a region too short for the displacement, then a full one
    task automatic test_lea_tail();
        program_signature(40'h8D_4805_8D48, 20'h10210, MODE_LEA, 64'hFFFF_F800_0000_1000);
        region_buf = '{8'h48, 8'h8D, 8'h05, 8'h00};
        send_region();
        region_buf = '{8'h48, 8'h8D, 8'h05, 8'hEF, 8'hBE, 8'hAD, 8'hDE};
        send_region();
        settle();
    endtask

    // receiver holds off while one-byte regions keep arriving
    task automatic test_result_backpressure();
        int i;
        hold_req = 1'b1;
        for (i = 0; i < 24; i++)
        begin
            region_buf = '{8'($urandom())};
            send_region();
        end
        settle();
    endtask

    task automatic test_random_regions();
        int            until_reconfig;
        int            r;
        region_shape_t shape;
        until_reconfig = 0;
        while (items_sent < ITEM_TARGET)
        begin
            if (until_reconfig == 0)
            begin
                settle();
                pick_random_signature();
                until_reconfig = $urandom_range(1, 5);
            end
            quiet = (items_sent > ITEM_TARGET * 85 / 100);
            r = $urandom_range(0, 99);
            if (r < 60)
                shape = REGION_SIGNATURE;
            else if (r < 75)
                shape = REGION_BROKEN;
            else if (r < 90)
                shape = REGION_NOISE;
            else
                shape = REGION_TRUNCATED;
            build_region(shape);
            send_region();
            until_reconfig--;
        end
    endtask

    // final drain with a bound, then report leftovers
    task automatic finish_run();
        int guard;
        byte_in_bus.valid <= 1'b0;
        guard = 0;
        while (pending_reports.size() != 0 && guard < 5000)
        begin
            @(negedge clk);
            guard++;
        end
        if (pending_reports.size() != 0)
        begin
            $error("%0d expected results never arrived", pending_reports.size());
            fail_count++;
        end
        repeat (3 * SETTLE_CYC) @(negedge clk);
    endtask

    // main sequence
    initial
    begin
        rst_n                  = 1'b0;
        byte_in_bus.valid      = 1'b0;
        byte_in_bus.data_byte  = '0;
        byte_in_bus.last_byte  = 1'b0;
        cfg_we                 = 1'b0;
        cfg_index              = REG_MATCH_VALUES;
        cfg_data               = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_defaults();
        test_plain_wrap();
        test_call_mode();
        test_mov_mode();
        test_lea_tail();
        test_result_backpressure();
        test_random_regions();
        finish_run();

        $display("scanned %0d bytes in %0d regions under %0d register settings",
                 items_sent, regions_sent, settings_cnt + 1);
        $display("results checked: %0d hits, %0d not-found, %0d errors",
                 hits_seen, misses_seen, fail_count);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
